FILE: rtl/dtmh_pkg.sv
// ----------------------------------------------------------------------------
// dtmh_pkg
// Shared types and constants of the deadline timer min-heap.
// ----------------------------------------------------------------------------
package dtmh_pkg;

    localparam int HEAP_DEPTH = 32;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = 5;
    localparam int DL_W       = 64;

    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(HEAP_DEPTH);

    typedef logic [DL_W-1:0]   deadline_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // One heap entry
    typedef struct packed {
        deadline_t deadline;
        slot_t     slot;
    } entry_t;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_EXPIRE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_PRESENT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_REM_POS,
        S_POP,
        S_TAKE,
        S_TAKE_RD,
        S_UP_RD,
        S_UP_CMP,
        S_DOWN_RD,
        S_DOWN_CMP,
        S_EMIT
    } fsm_t;

endpackage

FILE: rtl/dtmh_heap_ram.sv
// ----------------------------------------------------------------------------
// dtmh_heap_ram
// Heap entry memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module dtmh_heap_ram
    import dtmh_pkg::*;
(
    input  logic   aclk,
    input  logic   we,
    input  idx_t   waddr,
    input  entry_t wdata,
    input  idx_t   raddr_a,
    output entry_t rdata_a,
    input  idx_t   raddr_b,
    output entry_t rdata_b
);

    entry_t mem [HEAP_DEPTH];
    entry_t rdata_a_reg;
    entry_t rdata_b_reg;

    // Write one entry; read two, each read through a register
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: rtl/deadline_timer_min_heap.sv
// ----------------------------------------------------------------------------
// deadline_timer_min_heap
// Binary min-heap of task deadlines with per-slot removal and expiry.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add, remove and each expired entry walk
// the heap one level at a time (a read of the heap memory, then compare and
// write back); expire repeats that for every woken entry and emits one
// result per pop. A slot-position memory lets remove find its entry
// directly; the root is mirrored in a register for the nearest deadline. A
// finished result waits in the output register while the next request is
// accepted.
// ----------------------------------------------------------------------------
module deadline_timer_min_heap
    import dtmh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // task_slot[4:0], deadline[68:5], zero pad
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // woken_slot[4:0], woken_deadline[68:5],
                                    // nearest_deadline[132:69],
                                    // entry_count[138:133], zero pad
    output logic [2:0]   m_tuser,   // woken[0], status[2:1]
    output logic         m_tlast
);

    fsm_t      state_reg, state_next;
    req_t      req_reg, req_next;
    slot_t     slot_reg, slot_next;
    deadline_t time_reg, time_next;
    entry_t    cur_reg, cur_next;
    idx_t      pos_reg, pos_next;
    logic      moved_reg, moved_next;
    cnt_t      count_reg, count_next;
    logic [SLOT_COUNT-1:0] present_reg, present_next;
    entry_t    root_reg, root_next;
    entry_t    woke_reg, woke_next;
    slot_t     rm_slot_reg, rm_slot_next;
    status_t   status_reg, status_next;
    logic      woken_reg, woken_next;

    logic      out_valid_reg, out_valid_next;
    logic [143:0] out_data_reg, out_data_next;
    logic [2:0]   out_user_reg, out_user_next;
    logic      out_last_reg, out_last_next;

    // Heap memory ports
    logic      heap_we;
    idx_t      heap_waddr;
    entry_t    heap_wdata;
    idx_t      heap_raddr_a, heap_raddr_b;
    entry_t    heap_rdata_a, heap_rdata_b;

    // Slot position memory
    idx_t      posmem [SLOT_COUNT];
    logic      pos_we;
    slot_t     pos_waddr;
    idx_t      pos_wdata;
    slot_t     pos_raddr;
    idx_t      pos_rdata_reg;

    // Derived indexes
    idx_t      parent_idx;
    cnt_t      left_idx, right_idx;
    cnt_t      count_dec;
    entry_t    pick;
    cnt_t      pick_idx;
    logic      more_due;
    deadline_t s_deadline;
    slot_t     s_slot;

    assign s_slot     = s_tdata[4:0];
    assign s_deadline = s_tdata[68:5];
    assign s_tready   = (state_reg == S_IDLE);

    assign parent_idx = idx_t'((pos_reg - 1'b1) >> 1);
    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign count_dec  = count_reg - 1'b1;
    assign more_due   = (count_reg != '0) && (root_reg.deadline <= time_reg);

    dtmh_heap_ram u_heap_ram (
        .aclk    (aclk),
        .we      (heap_we),
        .waddr   (heap_waddr),
        .wdata   (heap_wdata),
        .raddr_a (heap_raddr_a),
        .rdata_a (heap_rdata_a),
        .raddr_b (heap_raddr_b),
        .rdata_b (heap_rdata_b)
    );

    // Slot position memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            posmem[pos_waddr] <= pos_wdata;
        end
        pos_rdata_reg <= posmem[pos_raddr];
    end

    // Choose the earlier child; left wins ties
    always_comb begin
        if ((right_idx < count_reg) &&
            (heap_rdata_b.deadline < heap_rdata_a.deadline)) begin
            pick     = heap_rdata_b;
            pick_idx = right_idx;
        end else begin
            pick     = heap_rdata_a;
            pick_idx = left_idx;
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        slot_next    = slot_reg;
        time_next    = time_reg;
        cur_next     = cur_reg;
        pos_next     = pos_reg;
        moved_next   = moved_reg;
        count_next   = count_reg;
        present_next = present_reg;
        woke_next    = woke_reg;
        rm_slot_next = rm_slot_reg;
        status_next  = status_reg;
        woken_next   = woken_reg;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        heap_we      = 1'b0;
        heap_waddr   = pos_reg;
        heap_wdata   = cur_reg;
        heap_raddr_a = parent_idx;
        heap_raddr_b = parent_idx;
        pos_we       = 1'b0;
        pos_waddr    = cur_reg.slot;
        pos_wdata    = pos_reg;
        pos_raddr    = slot_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next   = req_t'(s_tuser);
                    slot_next  = s_slot;
                    time_next  = s_deadline;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                status_next = ST_OK;
                woken_next  = 1'b0;
                moved_next  = 1'b0;
                unique case (req_reg)
                    REQ_ADD: begin
                        if (present_reg[slot_reg]) begin
                            status_next = ST_PRESENT;
                            state_next  = S_EMIT;
                        end else if (count_reg >= CAPACITY) begin
                            status_next = ST_FULL;
                            state_next  = S_EMIT;
                        end else begin
                            cur_next              = '{deadline: time_reg, slot: slot_reg};
                            pos_next              = idx_t'(count_reg);
                            count_next            = count_reg + 1'b1;
                            present_next[slot_reg] = 1'b1;
                            state_next            = S_UP_RD;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!present_reg[slot_reg]) begin
                            status_next = ST_ABSENT;
                            state_next  = S_EMIT;
                        end else begin
                            rm_slot_next = slot_reg;
                            state_next   = S_REM_POS;
                        end
                    end
                    REQ_EXPIRE: begin
                        state_next = more_due ? S_POP : S_EMIT;
                    end
                    default: begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_REM_POS: begin
                pos_next   = pos_rdata_reg;
                state_next = S_TAKE;
            end

            // Pop the root on expire
            S_POP: begin
                woke_next    = root_reg;
                rm_slot_next = root_reg.slot;
                pos_next     = '0;
                moved_next   = 1'b0;
                state_next   = S_TAKE;
            end

            // Drop the entry; fetch the last one to fill the hole
            S_TAKE: begin
                count_next                = count_dec;
                present_next[rm_slot_reg] = 1'b0;
                heap_raddr_a              = idx_t'(count_dec);
                if (cnt_t'(pos_reg) == count_dec) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_TAKE_RD;
                end
            end

            S_TAKE_RD: begin
                cur_next   = heap_rdata_a;
                state_next = S_UP_RD;
            end

            S_UP_RD: begin
                heap_raddr_a = parent_idx;
                if (pos_reg == '0) begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    state_next = (req_reg != REQ_ADD && !moved_reg) ? S_DOWN_RD : S_EMIT;
                end else begin
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                if (heap_rdata_a.deadline > cur_reg.deadline) begin
                    // Move parent down a level
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata_a;
                    pos_we     = 1'b1;
                    pos_waddr  = heap_rdata_a.slot;
                    pos_next   = parent_idx;
                    moved_next = 1'b1;
                    state_next = S_UP_RD;
                end else begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    state_next = (req_reg != REQ_ADD && !moved_reg) ? S_DOWN_RD : S_EMIT;
                end
            end

            S_DOWN_RD: begin
                heap_raddr_a = left_idx[IDX_W-1:0];
                heap_raddr_b = right_idx[IDX_W-1:0];
                if (left_idx >= count_reg) begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_DOWN_CMP;
                end
            end

            S_DOWN_CMP: begin
                if (cur_reg.deadline > pick.deadline) begin
                    // Move earlier child up a level
                    heap_we    = 1'b1;
                    heap_wdata = pick;
                    pos_we     = 1'b1;
                    pos_waddr  = pick.slot;
                    pos_next   = pick_idx[IDX_W-1:0];
                    state_next = S_DOWN_RD;
                end else begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_EMIT;
                end
            end

            // Hand the result to the output register
            S_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[138:133] = count_reg;
                    out_data_next[132:69]  = (count_reg != '0) ? root_reg.deadline : '1;
                    if (req_reg == REQ_EXPIRE && status_reg == ST_OK && woken_reg) begin
                        out_data_next[4:0]  = woke_reg.slot;
                        out_data_next[68:5] = woke_reg.deadline;
                        out_user_next       = {ST_OK, 1'b1};
                        out_last_next       = !more_due;
                        state_next          = more_due ? S_POP : S_IDLE;
                    end else begin
                        out_data_next[4:0] = slot_reg;
                        out_user_next      = {status_reg, 1'b0};
                        out_last_next      = 1'b1;
                        state_next         = S_IDLE;
                    end
                    woken_next = 1'b0;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Mark that this request popped something
        if (state_reg == S_POP) begin
            woken_next = 1'b1;
        end
    end

    // Mirror the root entry
    always_comb begin
        root_next = root_reg;
        if (heap_we && heap_waddr == '0) begin
            root_next = heap_wdata;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
            woken_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
            woken_reg     <= woken_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        slot_reg     <= slot_next;
        time_reg     <= time_next;
        cur_reg      <= cur_next;
        pos_reg      <= pos_next;
        moved_reg    <= moved_next;
        root_reg     <= root_next;
        woke_reg     <= woke_next;
        rm_slot_reg  <= rm_slot_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
